// ----- rtl/bmf_pkg.sv -----
// ----------------------------------------------------------------------------
// bmf_pkg: shared types and constants of the box mean filter
// Pixel and result beat structs, register indexes and divide helpers.
// ----------------------------------------------------------------------------
package bmf_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int REG_W   = 11;
    localparam int IDX_W   = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_KSIZE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE  = 2'd3;   // no register behind it

    typedef struct packed {
        logic [PIX_W-1:0] in_c0;
        logic [PIX_W-1:0] in_c1;
        logic [PIX_W-1:0] in_c2;
    } t_pix_in;

    typedef struct packed {
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic [PIX_W-1:0]   out_c0;
        logic [PIX_W-1:0]   out_c1;
        logic [PIX_W-1:0]   out_c2;
    } t_res_out;

    // per-pixel sequence
    typedef enum logic [2:0] {
        S_IDLE, S_WRITE, S_READ, S_COLSUM, S_WINSUM, S_DIV, S_OUT
    } t_state;

    // reciprocal of K*K scaled by 2^RECIP_SH, rounded up; exact for sums
    // below 2^14 (max 49*255 = 12495)
    localparam int RECIP_SH = 20;
    localparam int RECIP_W  = 18;

    function automatic logic [RECIP_W-1:0] recip(input logic [2:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            3'd1:    r = 18'h3FFFF; // handled as bypass
            3'd3:    r = 18'd116509;
            3'd5:    r = 18'd41944;
            3'd7:    r = 18'd21400;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/box_mean_filter_2d.sv -----
// ----------------------------------------------------------------------------
// box_mean_filter_2d: K x K box mean over a raster pixel stream
// Line stores feed column sums into a chain of column cells; the window sum
// is divided by K*K through a reciprocal multiply.
// ----------------------------------------------------------------------------
//  channel | signals                      | beat
//  --------+------------------------------+-------------------------------
//  pixel   | i_valid / o_ready / i_pix    | one raster pixel, 3 x 8 bits
//  result  | o_valid / i_ready / o_res    | centre position and 3 means
//  config  | i_cfg_we / i_cfg_idx / data  | one register write
//
// Each pixel passes through accept, line store write, one window row read
// per cycle (K rows, one RAM port; a zero kernel reads eight), then column
// sum, window sum, divide and output stages. A result waits in an output
// register; the next pixel is taken while it waits and stalls only in its
// output stage until that register frees. Reset clears counters and
// handshake state and sets K = 3, 1024 x 1024; line stores need no clearing.
module box_mean_filter_2d #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_KSIZE  = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  bmf_pkg::t_pix_in               i_pix,
    output logic                           o_valid,
    input  logic                           i_ready,
    output bmf_pkg::t_res_out              o_res,
    input  logic                           i_cfg_we,
    input  logic [bmf_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [bmf_pkg::REG_W-1:0]      i_cfg_data
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RHW   = $clog2(MAX_HEIGHT);
    localparam int KW    = $clog2(MAX_KSIZE + 1);
    localparam int SW    = $clog2(MAX_KSIZE);
    localparam int AW    = SW + CW;
    localparam int CSW   = $clog2(MAX_KSIZE * 255 + 1);
    localparam int WSW   = $clog2(MAX_KSIZE * MAX_KSIZE * 255 + 1);

    bmf_pkg::t_state r_state, n_state;

    // configuration registers and position counters
    logic [2:0]              r_ksize;
    logic [bmf_pkg::REG_W-1:0] r_width, r_height;
    logic [CW-1:0]           r_col;
    logic [RHW-1:0]          r_row;
    logic [SW-1:0]           r_row_slot; // r_row mod MAX_KSIZE

    // clamped dimensions
    logic [bmf_pkg::REG_W-1:0] w_eff, h_eff;
    always_comb begin
        w_eff = (r_width == '0) ? bmf_pkg::REG_W'(1) :
                (r_width > bmf_pkg::REG_W'(MAX_WIDTH)) ?
                bmf_pkg::REG_W'(MAX_WIDTH) : r_width;
        h_eff = (r_height == '0) ? bmf_pkg::REG_W'(1) :
                (r_height > bmf_pkg::REG_W'(MAX_HEIGHT)) ?
                bmf_pkg::REG_W'(MAX_HEIGHT) : r_height;
    end

    // captured pixel and position
    bmf_pkg::t_pix_in r_pix;
    logic [CW-1:0]    r_pc;
    logic [RHW-1:0]   r_pr;
    logic [SW-1:0]    r_slot;     // row % MAX_KSIZE of current pixel
    logic [SW-1:0]    r_rslot;    // slot being read
    logic [KW-1:0]    r_rcnt;     // rows read
    logic             r_rd_vld;
    logic [CSW-1:0]   r_csum [3];
    logic [WSW-1:0]   r_wsum [3];
    logic [WSW+bmf_pkg::RECIP_W-1:0] r_prod [3];
    logic             r_emit;
    bmf_pkg::t_res_out r_res;
    logic             r_ovld;

    logic accept;
    assign o_ready = (r_state == bmf_pkg::S_IDLE) && i_rst_n;
    assign accept  = i_valid && o_ready;

    // line store: address = {slot, col}, i.e. slot * 2^CW + col
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [23:0]      ram_rdata;
    assign ram_we    = (r_state == bmf_pkg::S_WRITE);
    assign ram_waddr = {r_slot, r_pc};
    assign ram_raddr = {r_rslot, r_pc};

    bmf_ram #(.WIDTH(24), .DEPTH(2 ** AW)) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_pix),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // window top slot: (slot - (K-1)) mod MAX_KSIZE
    logic [SW:0] top_slot;
    always_comb begin
        if ({1'b0, r_slot} >= (SW + 1)'(r_ksize - 3'd1)) begin
            top_slot = {1'b0, r_slot} - (SW + 1)'(r_ksize - 3'd1);
        end else begin
            top_slot = {1'b0, r_slot} + (SW + 1)'(MAX_KSIZE)
                       - (SW + 1)'(r_ksize - 3'd1);
        end
    end

    // column cells, column 0 at the left of the chain
    logic [3*CSW-1:0] cell_in  [MAX_KSIZE];
    logic [3*CSW-1:0] cell_out [MAX_KSIZE];
    logic             shift;
    assign shift = (r_state == bmf_pkg::S_WINSUM);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KSIZE; gi++) begin : g_cell
            if (gi == MAX_KSIZE - 1) begin : g_last
                assign cell_in[gi] = {r_csum[0], r_csum[1], r_csum[2]};
            end else begin : g_mid
                assign cell_in[gi] = cell_out[gi + 1];
            end
            bmf_cell #(.SUM_W(CSW)) u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_col   (cell_in[gi]),
                .o_col   (cell_out[gi])
            );
        end
    endgenerate

    // window sum over the rightmost K cells after shift
    logic [WSW-1:0] win [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            win[ch] = '0;
            for (int i = 0; i < MAX_KSIZE; i++) begin
                if (i >= MAX_KSIZE - int'(r_ksize)) begin
                    win[ch] = win[ch] + WSW'(cell_in[i][(2-ch)*CSW +: CSW]);
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bmf_pkg::S_IDLE:   if (accept) n_state = bmf_pkg::S_WRITE;
            bmf_pkg::S_WRITE:  n_state = bmf_pkg::S_READ;
            bmf_pkg::S_READ:   if (r_rcnt == KW'(r_ksize) - KW'(1)) begin
                n_state = bmf_pkg::S_COLSUM;
            end
            bmf_pkg::S_COLSUM: n_state = bmf_pkg::S_WINSUM;
            bmf_pkg::S_WINSUM: n_state = bmf_pkg::S_DIV;
            bmf_pkg::S_DIV:    n_state = bmf_pkg::S_OUT;
            bmf_pkg::S_OUT:    if (!r_ovld || i_ready) n_state = bmf_pkg::S_IDLE;
            default:           n_state = bmf_pkg::S_IDLE;
        endcase
    end

    // emit condition
    logic emit_ok;
    always_comb begin
        emit_ok = r_ksize[0] && (32'(r_ksize) <= MAX_KSIZE)
                  && (32'(r_pr) + 1 >= 32'(r_ksize))
                  && (32'(r_pc) + 1 >= 32'(r_ksize));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bmf_pkg::S_IDLE;
            r_ksize    <= 3'd3;
            r_width    <= bmf_pkg::REG_W'(1024);
            r_height   <= bmf_pkg::REG_W'(1024);
            r_col      <= '0;
            r_row      <= '0;
            r_row_slot <= '0;
            r_ovld     <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rcnt     <= '0;
        end else begin
            r_state <= n_state;
            // result register: load in the output stage, else clear on take
            if (r_state == bmf_pkg::S_OUT && (!r_ovld || i_ready) && r_emit) begin
                r_ovld <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_ovld <= 1'b0;
            end
            // configuration write
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bmf_pkg::REG_KSIZE:  r_ksize  <= i_cfg_data[2:0];
                    bmf_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                    bmf_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_idx inside {bmf_pkg::REG_KSIZE, bmf_pkg::REG_WIDTH,
                                      bmf_pkg::REG_HEIGHT}) begin
                    r_col      <= '0;
                    r_row      <= '0;
                    r_row_slot <= '0;
                end
            end else if (accept) begin
                // position counters
                if (32'(r_col) + 1 >= 32'(w_eff)) begin
                    r_col <= '0;
                    if (32'(r_row) + 1 >= 32'(h_eff)) begin
                        r_row      <= '0;
                        r_row_slot <= '0;
                    end else begin
                        r_row      <= r_row + RHW'(1);
                        r_row_slot <= (32'(r_row_slot) == MAX_KSIZE - 1) ?
                                      '0 : r_row_slot + SW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            r_rd_vld <= (r_state == bmf_pkg::S_READ);
            if (r_state == bmf_pkg::S_WRITE) begin
                r_rcnt <= '0;
            end else if (r_state == bmf_pkg::S_READ) begin
                r_rcnt <= r_rcnt + KW'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix  <= i_pix;
            r_pc   <= r_col;
            r_pr   <= r_row;
            r_slot <= r_row_slot;
        end
        if (r_state == bmf_pkg::S_WRITE) begin
            r_rslot <= top_slot[SW-1:0];
            for (int ch = 0; ch < 3; ch++) r_csum[ch] <= '0;
        end
        if (r_state == bmf_pkg::S_READ) begin
            r_rslot <= (32'(r_rslot) == MAX_KSIZE - 1) ? '0 : r_rslot + SW'(1);
        end
        if (r_rd_vld) begin
            r_csum[0] <= r_csum[0] + CSW'(ram_rdata[23:16]);
            r_csum[1] <= r_csum[1] + CSW'(ram_rdata[15:8]);
            r_csum[2] <= r_csum[2] + CSW'(ram_rdata[7:0]);
        end
        if (r_state == bmf_pkg::S_WINSUM) begin
            for (int ch = 0; ch < 3; ch++) r_wsum[ch] <= win[ch];
            r_emit <= emit_ok;
        end
        if (r_state == bmf_pkg::S_DIV) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_prod[ch] <= WSW'(r_wsum[ch]) * bmf_pkg::recip(r_ksize);
            end
        end
        if (r_state == bmf_pkg::S_OUT && (!r_ovld || i_ready) && r_emit) begin
            r_res.out_row <= 10'(r_pr - RHW'(r_ksize >> 1));
            r_res.out_col <= 10'(r_pc - CW'(r_ksize >> 1));
            if (r_ksize == 3'd1) begin
                r_res.out_c0 <= r_wsum[0][7:0];
                r_res.out_c1 <= r_wsum[1][7:0];
                r_res.out_c2 <= r_wsum[2][7:0];
            end else begin
                r_res.out_c0 <= 8'(r_prod[0] >> bmf_pkg::RECIP_SH);
                r_res.out_c1 <= 8'(r_prod[1] >> bmf_pkg::RECIP_SH);
                r_res.out_c2 <= 8'(r_prod[2] >> bmf_pkg::RECIP_SH);
            end
        end
    end

    assign o_valid = r_ovld;
    assign o_res   = r_res;
endmodule

// ----- rtl/bmf_ram.sv -----
// ----------------------------------------------------------------------------
// bmf_ram: generic single-port-write, single-port-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module bmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/bmf_cell.sv -----
// ----------------------------------------------------------------------------
// bmf_cell: one column cell of the window
// Holds the column sum of one window column (K rows, three channels) and
// hands it to its left neighbor each time a new column shifts in.
// ----------------------------------------------------------------------------
module bmf_cell #(
    parameter int SUM_W = 12
) (
    input  logic                 i_clk,
    input  logic                 i_shift,
    input  logic [3*SUM_W-1:0]   i_col,
    output logic [3*SUM_W-1:0]   o_col
);
    logic [3*SUM_W-1:0] r_col;

    // shift register stage, payload only
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
endmodule

// ----- rtl/bmf_checker.sv -----
// ----------------------------------------------------------------------------
// bmf_checker: port-level checks of the box mean filter
// Bound to the top level.
// ----------------------------------------------------------------------------
module bmf_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input bmf_pkg::t_res_out     o_res
);
    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("result changed under stall");

    // no pixel taken in the cycle after one is taken
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("back-to-back pixel beat");

    // after reset, no result is shown
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind box_mean_filter_2d bmf_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_res   (o_res)
);
